[hdl/ple_pkg.sv]
// shared types and constants for the positional list engine
// no dependencies; imported by the interfaces, the cell and the top level
`default_nettype none

package ple_pkg;

  // default sizes
  localparam int unsigned PLE_CAPACITY  = 16;
  localparam int unsigned PLE_ITEM_BITS = 32;
  localparam int unsigned PLE_POS_BITS  = $clog2(PLE_CAPACITY + 1);
  localparam int unsigned KIND_BITS     = 3;

  // request kinds
  typedef enum logic [KIND_BITS-1:0] {
    KIND_INS_FRONT = 3'd0,
    KIND_INS_BACK  = 3'd1,
    KIND_INS_POS   = 3'd2,
    KIND_REMOVE    = 3'd3,
    KIND_READ      = 3'd4
  } ple_kind_t;

  // shift command broadcast to every cell
  typedef struct packed {
    logic ins_en;   // open a gap at the position and place the new word
    logic rem_en;   // close the gap at the position
  } ple_shift_t;

endpackage

`default_nettype wire

[hdl/ple_if.sv]
// valid/ready channel interfaces for requests and results
// depends on ple_pkg for the kind width and default sizes
`default_nettype none

interface ple_in_if import ple_pkg::*; #(
  parameter int unsigned POS_BITS  = PLE_POS_BITS,
  parameter int unsigned ITEM_BITS = PLE_ITEM_BITS
);
  logic                 valid;
  logic                 ready;
  logic [KIND_BITS-1:0] kind;
  logic [POS_BITS-1:0]  position;
  logic [ITEM_BITS-1:0] item;

  modport source (output valid, kind, position, item, input ready);
  modport sink   (input valid, kind, position, item, output ready);
endinterface

interface ple_out_if import ple_pkg::*; #(
  parameter int unsigned POS_BITS  = PLE_POS_BITS,
  parameter int unsigned ITEM_BITS = PLE_ITEM_BITS
);
  logic                 valid;
  logic                 ready;
  logic                 ok;
  logic [ITEM_BITS-1:0] item_out;
  logic [POS_BITS-1:0]  count;
  logic                 empty_res;

  modport source (output valid, ok, item_out, count, empty_res, input ready);
  modport sink   (input valid, ok, item_out, count, empty_res, output ready);
endinterface

`default_nettype wire

[hdl/ple_cell.sv]
// one list slot: holds a word and shifts with its neighbors on insert/remove
// depends on ple_pkg for the shift command struct
`default_nettype none

module ple_cell import ple_pkg::*; #(
  parameter int unsigned ITEM_BITS = PLE_ITEM_BITS,
  parameter int unsigned POS_BITS  = PLE_POS_BITS,
  parameter int unsigned IDX       = 0
) (
  input  wire logic                 clk,
  input  wire ple_shift_t           shift,
  input  wire logic [POS_BITS-1:0]  position,
  input  wire logic [ITEM_BITS-1:0] new_item,
  input  wire logic [ITEM_BITS-1:0] left_item,
  input  wire logic [ITEM_BITS-1:0] right_item,
  output logic      [ITEM_BITS-1:0] slot_q
);

  localparam logic [POS_BITS-1:0] IDX_V = POS_BITS'(IDX);

  logic [ITEM_BITS-1:0] slot_r;
  logic [ITEM_BITS-1:0] slot_nxt;

  // pick the next word from the neighbor or the request
  always_comb begin
    slot_nxt = slot_r;
    if (shift.ins_en) begin
      if (IDX_V == position) begin
        slot_nxt = new_item;
      end else if (IDX_V > position) begin
        slot_nxt = left_item;
      end
    end else if (shift.rem_en) begin
      if (IDX_V >= position) begin
        slot_nxt = right_item;
      end
    end
  end

  // payload register, no reset
  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

  assign slot_q = slot_r;

endmodule

`default_nettype wire

[hdl/positional_list_engine.sv]
// top level of the positional list engine: row of slot cells, length counter
// and registered result stage; depends on ple_pkg, ple_if and ple_cell
`default_nettype none

// Ordered list of up to CAPACITY handles of ITEM_BITS bits each.
// Requests arrive as words on in_req (valid/ready): kind selects insert at
// front, insert at back, insert at position, remove at position or read at
// position. Each request gives exactly one result word on out_rsp
// (valid/ready) with ok, the removed or read handle, the new length and an
// empty flag. Failed requests (bad position, full list, unknown kind) give
// ok=0, item_out=0 and leave the list as it was.
// out_rsp.valid rises in the cycle after acceptance. Throughput is one
// request per cycle while out_rsp is not stalled: every cell from the
// position on takes its new word in the same cycle, so an insert or remove
// moves the list at once, and the read port is one mux over the cells.
// in_req.ready is high while the result register is empty or being taken,
// so a stalled receiver holds one result and then stalls the sender.
// Reset clears the length and the result valid; the slot contents are not
// cleared and are only ever read inside the current length.
module positional_list_engine import ple_pkg::*; #(
  parameter int unsigned CAPACITY  = PLE_CAPACITY,
  parameter int unsigned ITEM_BITS = PLE_ITEM_BITS
) (
  input  wire logic clk,
  input  wire logic rst_n,
  ple_in_if.sink    in_req,
  ple_out_if.source out_rsp
);

  localparam int unsigned POS_BITS = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_BITS = $clog2(CAPACITY);
  localparam logic [POS_BITS-1:0] CAP_V = POS_BITS'(CAPACITY);

  logic [POS_BITS-1:0]  count_r;
  logic [POS_BITS-1:0]  count_nxt;
  logic                 out_valid_r;
  logic                 ok_r;
  logic [ITEM_BITS-1:0] item_out_r;
  logic [POS_BITS-1:0]  count_out_r;
  logic                 empty_r;

  logic                 fire;
  logic [POS_BITS-1:0]  eff_pos;
  logic                 is_ins;
  logic                 ins_ok;
  logic                 rem_ok;
  logic                 rd_ok;
  logic                 req_ok;
  logic [ITEM_BITS-1:0] fetched;
  ple_shift_t           shift;
  logic [ITEM_BITS-1:0] slot_q [CAPACITY];

  // handshake
  assign in_req.ready = !out_valid_r || out_rsp.ready;
  assign fire         = in_req.valid && in_req.ready;

  // decode request and check position against the length
  always_comb begin
    eff_pos = in_req.position;
    is_ins  = 1'b0;
    case (ple_kind_t'(in_req.kind))
      KIND_INS_FRONT: begin
        eff_pos = '0;
        is_ins  = 1'b1;
      end
      KIND_INS_BACK: begin
        eff_pos = count_r;
        is_ins  = 1'b1;
      end
      KIND_INS_POS: begin
        is_ins  = 1'b1;
      end
      default: begin
        is_ins  = 1'b0;
      end
    endcase
  end

  assign ins_ok = is_ins && (count_r != CAP_V) && (eff_pos <= count_r);
  assign rem_ok = (in_req.kind == KIND_REMOVE) && (in_req.position < count_r);
  assign rd_ok  = (in_req.kind == KIND_READ) && (in_req.position < count_r);
  assign req_ok = ins_ok || rem_ok || rd_ok;

  assign shift.ins_en = fire && ins_ok;
  assign shift.rem_en = fire && rem_ok;

  // row of cells, each linked to its neighbors
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ITEM_BITS-1:0] left_w;
    logic [ITEM_BITS-1:0] right_w;
    if (i == 0) begin : g_first
      assign left_w = in_req.item;
    end else begin : g_mid_l
      assign left_w = slot_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = slot_q[i];
    end else begin : g_mid_r
      assign right_w = slot_q[i+1];
    end
    ple_cell #(
      .ITEM_BITS (ITEM_BITS),
      .POS_BITS  (POS_BITS),
      .IDX       (i)
    ) u_cell (
      .clk        (clk),
      .shift      (shift),
      .position   (eff_pos),
      .new_item   (in_req.item),
      .left_item  (left_w),
      .right_item (right_w),
      .slot_q     (slot_q[i])
    );
  end

  // read port over the cells
  assign fetched = slot_q[in_req.position[IDX_BITS-1:0]];

  // length update
  always_comb begin
    count_nxt = count_r;
    if (shift.ins_en) begin
      count_nxt = count_r + POS_BITS'(1);
    end else if (shift.rem_en) begin
      count_nxt = count_r - POS_BITS'(1);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (fire) begin
      ok_r        <= req_ok;
      item_out_r  <= (rem_ok || rd_ok) ? fetched : '0;
      count_out_r <= count_nxt;
      empty_r     <= (count_nxt == '0);
    end
  end

  assign out_rsp.valid     = out_valid_r;
  assign out_rsp.ok        = ok_r;
  assign out_rsp.item_out  = item_out_r;
  assign out_rsp.count     = count_out_r;
  assign out_rsp.empty_res = empty_r;

endmodule

`default_nettype wire

[bench/tb_top.sv]
`timescale 1ns / 1ps
// self-checking bench for positional_list_engine: queue-fed driver, clocked monitor
// and an in-bench list predictor; depends on ple_pkg, ple_if and the engine rtl

module tb_top;
  import ple_pkg::*;

  localparam int unsigned LIST_CAP     = PLE_CAPACITY;
  localparam int unsigned POS_W        = PLE_POS_BITS;
  localparam int unsigned WORD_W       = PLE_ITEM_BITS;
  localparam int unsigned TARGET_REQS  = 650;
  localparam int unsigned TAIL_ITEMS   = 60;
  localparam int unsigned SETTLE_CYC   = 8;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned MAX_REPORTS  = 10;

  // kind codes the block does not define
  localparam bit [KIND_BITS-1:0] KIND_UNKNOWN_FIRST = 3'd5;
  localparam bit [KIND_BITS-1:0] KIND_UNKNOWN_LAST  = 3'd7;

  typedef struct packed {
    bit [KIND_BITS-1:0] kind;
    bit [POS_W-1:0]     position;
    bit [WORD_W-1:0]    item;
    bit                 hold;   // wait for every outstanding result before sending
  } list_req_t;

  typedef struct packed {
    logic              ok;
    logic [WORD_W-1:0] item_out;
    logic [POS_W-1:0]  count;
    logic              empty_res;
  } list_rsp_t;

  logic clk;
  logic rst_n;

  ple_in_if  #(.POS_BITS(POS_W), .ITEM_BITS(WORD_W)) req_if ();
  ple_out_if #(.POS_BITS(POS_W), .ITEM_BITS(WORD_W)) rsp_if ();

  positional_list_engine u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_if),
    .out_rsp (rsp_if)
  );

  // bench state
  list_req_t   req_backlog[$];
  list_rsp_t   awaited_rsp[$];
  bit [WORD_W-1:0] shadow_list[$];
  list_req_t   next_req;
  list_rsp_t   want_rsp;
  list_rsp_t   seen_rsp;
  bit          req_taken;
  bit          in_tail;
  int unsigned gen_len;
  int unsigned real_reqs;
  int unsigned gap_left;
  int unsigned stall_left;
  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  int unsigned words_sent;
  int unsigned cycles;
  int unsigned n_accepted;
  int unsigned n_checked;
  int unsigned n_rejected;
  int unsigned n_full;
  int unsigned n_empty;
  int unsigned n_errors;

  // clock
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // list predictor: applies one request to the shadow list and returns its result word
  function automatic list_rsp_t list_op_result(bit [KIND_BITS-1:0] kind,
                                               bit [POS_W-1:0] pos, bit [WORD_W-1:0] val);
    list_rsp_t   res;
    int unsigned at;
    res = '0;
    case (kind)
      KIND_INS_FRONT, KIND_INS_BACK, KIND_INS_POS: begin
        if (kind == KIND_INS_FRONT) at = 0;
        else if (kind == KIND_INS_BACK) at = shadow_list.size();
        else at = 32'(pos);
        if (shadow_list.size() < LIST_CAP && at <= shadow_list.size()) begin
          shadow_list.insert(at, val);
          res.ok = 1'b1;
        end
      end
      KIND_REMOVE: begin
        if (pos < shadow_list.size()) begin
          res.item_out = shadow_list[pos];
          shadow_list.delete(pos);
          res.ok = 1'b1;
        end
      end
      KIND_READ: begin
        if (pos < shadow_list.size()) begin
          res.item_out = shadow_list[pos];
          res.ok = 1'b1;
        end
      end
      default: ;
    endcase
    res.count     = POS_W'(shadow_list.size());
    res.empty_res = (shadow_list.size() == 0);
    return res;
  endfunction

  // queue one request and track the length it leaves, for shaping positions
  task automatic add_req(bit [KIND_BITS-1:0] kind, bit [POS_W-1:0] pos,
                         bit [WORD_W-1:0] val, bit hold);
    list_req_t   r;
    int unsigned at;
    r.kind     = kind;
    r.position = pos;
    r.item     = val;
    r.hold     = hold;
    req_backlog.push_back(r);
    case (kind)
      KIND_INS_FRONT, KIND_INS_BACK, KIND_INS_POS: begin
        if (kind == KIND_INS_FRONT) at = 0;
        else if (kind == KIND_INS_BACK) at = gen_len;
        else at = 32'(pos);
        if (gen_len < LIST_CAP && at <= gen_len) gen_len++;
      end
      KIND_REMOVE: if (pos < gen_len) gen_len--;
      default: ;
    endcase
  endtask

  // one phase of random requests, biased toward filling, draining or mixed use
  task automatic add_phase(int unsigned n, int unsigned ins_pct, int unsigned rem_pct);
    int unsigned        roll;
    bit [KIND_BITS-1:0] kind;
    bit [POS_W-1:0]     pos;
    bit [WORD_W-1:0]    val;
    for (int unsigned i = 0; i < n; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        kind = KIND_BITS'($urandom_range(KIND_UNKNOWN_FIRST, KIND_UNKNOWN_LAST));
      end else if (roll < 3 + ins_pct) begin
        case ($urandom_range(0, 2))
          0:       kind = KIND_INS_FRONT;
          1:       kind = KIND_INS_BACK;
          default: kind = KIND_INS_POS;
        endcase
      end else if (roll < 3 + ins_pct + rem_pct) begin
        kind = KIND_REMOVE;
      end else begin
        kind = KIND_READ;
      end
      // mostly legal positions, some anywhere in the field
      if ($urandom_range(0, 9) == 0) pos = POS_W'($urandom_range(0, 31));
      else if (kind == KIND_INS_POS) pos = POS_W'($urandom_range(0, gen_len));
      else if (gen_len == 0) pos = '0;
      else pos = POS_W'($urandom_range(0, gen_len - 1));
      case ($urandom_range(0, 15))
        0:       val = '0;
        1:       val = '1;
        default: val = $urandom;
      endcase
      add_req(kind, pos, val, i == 0);
      if (kind < KIND_UNKNOWN_FIRST) real_reqs++;
    end
  endtask

  function automatic int unsigned pick_idle_pct();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 10;
      default: return 35;
    endcase
  endfunction

  task automatic note_mismatch(string what, list_rsp_t want, list_rsp_t got);
    n_errors++;
    if (n_errors <= MAX_REPORTS) begin
      $display("[%0d] %0s: want ok=%0d item=%h count=%0d empty=%0d", cycles, what,
               want.ok, want.item_out, want.count, want.empty_res);
      $display("      got  ok=%0d item=%h count=%0d empty=%0d",
               got.ok, got.item_out, got.count, got.empty_res);
    end
  endtask

  // monitor: predict on each accepted request, check each accepted result word
  always @(posedge clk) begin
    cycles++;
    req_taken = 1'b0;
    in_tail   = (req_backlog.size() <= TAIL_ITEMS);
    if (rst_n) begin
      if (req_if.valid && req_if.ready) begin
        req_taken = 1'b1;
        want_rsp  = list_op_result(req_if.kind, req_if.position, req_if.item);
        awaited_rsp.push_back(want_rsp);
        n_accepted++;
        if (!want_rsp.ok) n_rejected++;
        if (want_rsp.count == LIST_CAP) n_full++;
        if (want_rsp.empty_res) n_empty++;
      end
      if (rsp_if.valid && rsp_if.ready) begin
        seen_rsp.ok        = rsp_if.ok;
        seen_rsp.item_out  = rsp_if.item_out;
        seen_rsp.count     = rsp_if.count;
        seen_rsp.empty_res = rsp_if.empty_res;
        if (awaited_rsp.size() == 0) begin
          note_mismatch("result with nothing outstanding", '0, seen_rsp);
        end else begin
          want_rsp = awaited_rsp.pop_front();
          if (seen_rsp.ok !== want_rsp.ok || seen_rsp.item_out !== want_rsp.item_out ||
              seen_rsp.count !== want_rsp.count ||
              seen_rsp.empty_res !== want_rsp.empty_res) begin
            note_mismatch("result mismatch", want_rsp, seen_rsp);
          end
          n_checked++;
        end
      end
    end
  end

  // request driver: next word from the backlog, with random gap bursts
  always @(negedge clk) begin
    if (rst_n && (req_taken || !req_if.valid)) begin
      if (gap_left != 0) begin
        gap_left     <= gap_left - 1;
        req_if.valid <= 1'b0;
      end else if (req_backlog.size() != 0 &&
                   !(req_backlog[0].hold && awaited_rsp.size() != 0)) begin
        next_req        = req_backlog.pop_front();
        req_if.kind     <= next_req.kind;
        req_if.position <= next_req.position;
        req_if.item     <= next_req.item;
        req_if.valid    <= 1'b1;
        words_sent++;
        if (words_sent % 50 == 0) src_idle_pct = pick_idle_pct();
        if (!in_tail && $urandom_range(0, 99) < src_idle_pct) gap_left <= $urandom_range(1, 16);
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // result sink: random stall bursts
  always @(negedge clk) begin
    if (rst_n) begin
      if (cycles % 97 == 0) snk_idle_pct = pick_idle_pct();
      if (stall_left != 0) begin
        stall_left   <= stall_left - 1;
        rsp_if.ready <= 1'b0;
      end else if (!in_tail && $urandom_range(0, 99) < snk_idle_pct) begin
        stall_left   <= $urandom_range(0, 15);
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // watchdog
  initial begin
    while (cycles < CYCLE_LIMIT) @(negedge clk);
    $display("timeout after %0d cycles", cycles);
    $display("Regression FAIL");
    $finish;
  end

  // stimulus and end of run
  initial begin
    int unsigned phase;
    rst_n           = 1'b0;
    req_if.valid    = 1'b0;
    req_if.kind     = '0;
    req_if.position = '0;
    req_if.item     = '0;
    rsp_if.ready    = 1'b0;
    src_idle_pct    = 10;
    snk_idle_pct    = 10;

    // directed: empty list, edges of position and item, unknown kinds
    add_req(KIND_READ,          5'd0,  32'h0,        1'b0);
    add_req(KIND_REMOVE,        5'd0,  32'h0,        1'b0);
    add_req(KIND_INS_POS,       5'd1,  32'h0000_1234, 1'b0);
    add_req(KIND_UNKNOWN_LAST,  5'd31, 32'hFFFF_FFFF, 1'b0);
    add_req(KIND_INS_FRONT,     5'd31, 32'hFFFF_FFFF, 1'b0);
    add_req(KIND_INS_BACK,      5'd0,  32'h0000_0000, 1'b0);
    add_req(KIND_INS_POS,       5'd1,  32'hA5A5_A5A5, 1'b0);
    add_req(KIND_INS_POS,       5'd3,  32'h5A5A_5A5A, 1'b0);
    add_req(KIND_INS_POS,       5'd0,  32'h0000_0001, 1'b0);
    add_req(KIND_READ,          5'd0,  32'h0,        1'b0);
    add_req(KIND_READ,          5'd4,  32'h0,        1'b0);
    add_req(KIND_READ,          5'd5,  32'h0,        1'b0);
    add_req(KIND_READ,          5'd31, 32'h0,        1'b0);
    add_req(KIND_REMOVE,        5'd2,  32'h0,        1'b0);
    add_req(KIND_REMOVE,        5'd31, 32'h0,        1'b0);
    add_req(KIND_REMOVE,        5'd3,  32'h0,        1'b0);
    add_req(KIND_INS_POS,       5'd16, 32'h8000_0000, 1'b0);
    add_req(KIND_UNKNOWN_FIRST, 5'd16, 32'h7FFF_FFFF, 1'b0);

    // random phases: the first pushes toward a full list, the second toward an empty one
    phase = 0;
    while (real_reqs < TARGET_REQS) begin
      case ((phase < 2) ? phase : $urandom_range(0, 3))
        0:       add_phase($urandom_range(30, 45), 85, 5);
        1:       add_phase($urandom_range(30, 45), 10, 75);
        2:       add_phase($urandom_range(25, 60), 40, 35);
        default: add_phase($urandom_range(25, 60), 20, 20);
      endcase
      phase++;
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (req_backlog.size() != 0 || req_if.valid) @(negedge clk);
    while (awaited_rsp.size() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);

    $display("%0d requests sent, %0d result words checked, %0d rejected", n_accepted,
             n_checked, n_rejected);
    $display("list at capacity %0d times, empty %0d times, %0d cycles", n_full, n_empty,
             cycles);
    if (n_errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/ple_pkg.sv
hdl/ple_if.sv
hdl/ple_cell.sv
hdl/positional_list_engine.sv
bench/tb_top.sv
